@@ src/mae_pkg.sv @@
// ----------------------------------------------------------------------------
// mae_pkg
// Shared constants of the moving-average estimator: configuration register
// width and reset value, and the quotient bits resolved per divider cycle.
// ----------------------------------------------------------------------------
package mae_pkg;

  // window length register
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd10;

  // quotient bits per divider cycle
  localparam int unsigned DIV_RADIX_BITS = 4;

endpackage

@@ src/moving_average_estimator_core.sv @@
// ----------------------------------------------------------------------------
// moving_average_estimator_core
// Per-channel simple moving average over a ring of recent sample vectors,
// with exact running sums and a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  : one item is a vector of NUM_LOADS signed samples.
//   m_axis_*  : one result per item, the truncated per-channel means in tdata
//               and the window-full flag in tuser.
//   cfg_*     : writes the window length. Every write restarts averaging with
//               an empty ring; it wins over an input item offered alongside.
// Sequence: an accepted item passes through the update state, then for each
//   channel an operand load and the divider iterations, then the done state,
//   which hands the result to the output register; the next item is taken
//   once the sequencer is back in idle. The work is done by the single shared
//   divider, which resolves four quotient bits a cycle, one channel after
//   another.
// Reset: window length returns to 10, sums and counters clear, no output valid.
//   The ring itself is not cleared; entries are only read once written.
// Stall: the result waits in the output register while m_axis_tready_i is
//   low. A new item may already be accepted and worked on meanwhile; it waits
//   in the done state until the output register is free.
// ----------------------------------------------------------------------------
module moving_average_estimator_core #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned NUM_LOADS   = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mae_pkg::CFG_W-1:0]    cfg_data_i,     // window length
  // input item stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // load_0 .. load_{NUM_LOADS-1}, SAMPLE_BITS each, then zero fill to bytes
  input  logic [((NUM_LOADS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // estimate_0 .. estimate_{NUM_LOADS-1}, SAMPLE_BITS each, then zero fill
  output logic [((NUM_LOADS*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                         m_axis_tuser_o  // window_full
);

  import mae_pkg::*;

  localparam int unsigned SB       = SAMPLE_BITS;
  localparam int unsigned IN_W     = NUM_LOADS * SB;
  localparam int unsigned CW       = $clog2(WINDOW_MAX + 1);   // fill count
  localparam int unsigned SLOT_W   = $clog2(WINDOW_MAX);       // ring address
  localparam int unsigned SUM_W    = SB + CW;                  // exact sum
  localparam int unsigned DIV_STEPS = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int unsigned DVD_W    = DIV_STEPS * DIV_RADIX_BITS;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);
  localparam int unsigned CH_W     = (NUM_LOADS > 1) ? $clog2(NUM_LOADS) : 1;
  localparam int unsigned WCMP_W   = CW + CFG_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;  // ring write and sum update
  localparam logic [2:0] ST_LOAD = 3'd2;  // divider operand load
  localparam logic [2:0] ST_DIV  = 3'd3;  // divider iterations
  localparam logic [2:0] ST_DONE = 3'd4;  // hand result to output register

  logic [2:0]          state_q, state_d;
  logic [CFG_W-1:0]    win_q;
  logic [CW-1:0]       fill_q, fill_d;
  logic [SLOT_W-1:0]   oldest_q, oldest_d;
  logic [CH_W-1:0]     chan_q, chan_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;

  logic signed [SUM_W-1:0] sum_q [NUM_LOADS];

  logic [IN_W-1:0]     samp_q;
  logic [IN_W-1:0]     old_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                repl_q;
  logic                full_q;
  logic [CW-1:0]       rem_q;
  logic [DVD_W-1:0]    dvd_q;
  logic                neg_q;
  logic [SB-1:0]       est_q [NUM_LOADS];
  logic [SB-1:0]       out_est_q [NUM_LOADS];
  logic                out_full_q;

  logic [IN_W-1:0]     ring_mem [WINDOW_MAX];

  logic                in_acc, cfg_acc, out_acc, out_free;
  logic [WCMP_W-1:0]   win_ext;
  logic [CW-1:0]       w_eff;
  logic                replace_now;
  logic [SLOT_W-1:0]   slot_now;
  logic [CW-1:0]       slot_inc;

  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]    sum_mag;
  logic [CW-1:0]       rem_n;
  logic [DVD_W-1:0]    dvd_n;
  logic [CW:0]         trial;
  logic [DVD_W-1:0]    quot;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // a pending register write goes first, the item is taken once no write is pending
  assign s_axis_tready_o = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_full_q;

  always_comb begin
    m_axis_tdata_o = '0;
    for (int i = 0; i < NUM_LOADS; i++) begin
      m_axis_tdata_o[i*SB +: SB] = out_est_q[i];
    end
  end

  // effective window: zero reads as one, clamp at WINDOW_MAX
  assign win_ext = WCMP_W'(win_q);
  always_comb begin
    if (win_q == '0) begin
      w_eff = CW'(1);
    end else if (win_ext > WCMP_W'(WINDOW_MAX)) begin
      w_eff = CW'(WINDOW_MAX);
    end else begin
      w_eff = win_ext[CW-1:0];
    end
  end

  assign replace_now = (fill_q >= w_eff);
  assign slot_now    = replace_now ? oldest_q : fill_q[SLOT_W-1:0];
  assign slot_inc    = CW'(slot_now) + CW'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    chan_d      = chan_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          fill_d   = '0;
          oldest_d = '0;
        end else if (in_acc) begin
          state_d = ST_UPD;
          if (replace_now) begin
            oldest_d = (slot_inc == w_eff) ? '0 : slot_inc[SLOT_W-1:0];
          end else begin
            fill_d = fill_q + CW'(1);
          end
        end
      end
      ST_UPD: begin
        state_d = ST_LOAD;
        chan_d  = '0;
      end
      ST_LOAD: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          if (chan_q == CH_W'(NUM_LOADS - 1)) begin
            state_d = ST_DONE;
          end else begin
            chan_d  = chan_q + CH_W'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // shared divider: DIV_RADIX_BITS restoring steps per cycle, narrow remainder
  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    trial = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      trial = {rem_n, dvd_n[DVD_W-1]};
      if (trial >= {1'b0, fill_q}) begin
        trial = trial - {1'b0, fill_q};
        dvd_n = {dvd_n[DVD_W-2:0], 1'b1};
      end else begin
        dvd_n = {dvd_n[DVD_W-2:0], 1'b0};
      end
      rem_n = trial[CW-1:0];
    end
  end

  assign quot    = neg_q ? (~dvd_n + DVD_W'(1)) : dvd_n;
  assign sum_sel = sum_q[chan_q];
  assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WINDOW_RESET;
      fill_q      <= '0;
      oldest_q    <= '0;
      chan_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LOADS; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      chan_q      <= chan_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_acc) begin
        win_q <= cfg_data_i;
        for (int i = 0; i < NUM_LOADS; i++) begin
          sum_q[i] <= '0;
        end
      end else if (state_q == ST_UPD) begin
        for (int i = 0; i < NUM_LOADS; i++) begin
          sum_q[i] <= sum_q[i]
                    + SUM_W'(signed'(samp_q[i*SB +: SB]))
                    - (repl_q ? SUM_W'(signed'(old_q[i*SB +: SB])) : '0);
        end
      end
    end
  end

  // datapath and ring
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q <= s_axis_tdata_i[IN_W-1:0];
      slot_q <= slot_now;
      repl_q <= replace_now;
      old_q  <= ring_mem[slot_now];
    end
    if (state_q == ST_UPD) begin
      ring_mem[slot_q] <= samp_q;
      full_q           <= (fill_q == w_eff);
    end
    if (state_q == ST_LOAD) begin
      rem_q <= '0;
      dvd_q <= DVD_W'(sum_mag);
      neg_q <= sum_sel[SUM_W-1];
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_n;
      dvd_q <= dvd_n;
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        est_q[chan_q] <= quot[SB-1:0];
      end
    end
    if (state_q == ST_DONE && out_free) begin
      for (int i = 0; i < NUM_LOADS; i++) begin
        out_est_q[i] <= est_q[i];
      end
      out_full_q <= full_q;
    end
  end

`ifndef SYNTH
  a_accept_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_UPD)
    else $error("accepted item did not start the update step");

  a_fill_within_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= w_eff)
    else $error("fill count exceeds the window");

  a_oldest_within_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < w_eff)
    else $error("oldest slot outside the window");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_DIV) |-> fill_q != '0)
    else $error("divide by a zero count");

  a_result_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_free) |=> state_q == ST_DONE)
    else $error("result dropped while output register busy");
`endif

endmodule

@@ sim/tb_moving_average_estimator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_estimator_core
// Self-checking bench for the moving-average estimator. Load vectors go in
// through a queue-fed driver. Each accepted vector updates a local
// moving-average model, which queues the expected means and window-full flag.
// A monitor checks each result against the oldest expectation. The run sweeps
// window settings, including out-of-range values, under several idle patterns.
// ----------------------------------------------------------------------------
module tb_moving_average_estimator_core;

  import mae_pkg::CFG_W;
  import mae_pkg::WINDOW_RESET;

  localparam int unsigned WINDOW_MAX  = 64;
  localparam int unsigned NUM_LOADS   = 4;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned DATA_W      = ((NUM_LOADS*SAMPLE_BITS+7)/8)*8;
  localparam int unsigned SUM_W       = 23;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 40;   // beyond the item processing time
  localparam int unsigned RAND_ITEMS  = 1600;

  typedef logic [DATA_W-1:0] load_vec_t;
  typedef struct packed {
    logic [DATA_W-1:0] means;
    logic              full;
  } mean_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [DATA_W-1:0] s_axis_tdata_i = '0;   // load_0 .. load_3
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata_o;        // estimate_0 .. estimate_3
  logic             m_axis_tuser_o;         // window_full

  moving_average_estimator_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // model state
  logic signed [SAMPLE_BITS-1:0] ring_q [WINDOW_MAX][NUM_LOADS];
  logic signed [SUM_W-1:0]       sums_q [NUM_LOADS];
  logic [6:0]                    fill_cnt;
  logic [5:0]                    oldest_slot;
  logic [CFG_W-1:0]              window_reg;

  load_vec_t    pending_loads [$];
  mean_result_t expected_means [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  bit          load_taken    = 1'b0;
  int unsigned mismatch_cnt  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Any write restarts averaging; out-of-range windows are clamped on use only.
  function automatic void window_restart(logic [CFG_W-1:0] value);
    window_reg  = value;
    fill_cnt    = '0;
    oldest_slot = '0;
    for (int ch = 0; ch < NUM_LOADS; ch++) sums_q[ch] = '0;
  endfunction

  function automatic mean_result_t average_update(load_vec_t loads);
    mean_result_t r;
    int unsigned w;
    logic [5:0] slot;
    logic signed [SAMPLE_BITS-1:0] fresh;
    w = (window_reg == 0) ? 1 : (window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg;
    if (fill_cnt < w) begin
      slot = fill_cnt[5:0];
      fill_cnt++;
    end else begin
      // ring full: retire the oldest vector
      slot = 6'(oldest_slot % w);
      for (int ch = 0; ch < NUM_LOADS; ch++) sums_q[ch] -= ring_q[slot][ch];
      oldest_slot = 6'((slot + 1) % w);
    end
    for (int ch = 0; ch < NUM_LOADS; ch++) begin
      fresh = loads[ch*SAMPLE_BITS +: SAMPLE_BITS];
      sums_q[ch] += fresh;
      ring_q[slot][ch] = fresh;
    end
    // signed divide truncates toward zero
    for (int ch = 0; ch < NUM_LOADS; ch++)
      r.means[ch*SAMPLE_BITS +: SAMPLE_BITS] =
        SAMPLE_BITS'(sums_q[ch] / $signed({1'b0, fill_cnt}));
    r.full = (fill_cnt == w);
    return r;
  endfunction

  function automatic void add_load(load_vec_t v);
    pending_loads.insert(pending_loads.size(), v);
  endfunction

  task automatic flag_mismatch(string what, longint want, longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // input driver: holds an item until taken, idles at random between items
  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && !load_taken)) begin
      // keep offering
    end else if (pending_loads.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= pending_loads.pop_front();
      load_taken = 1'b0;
    end else begin
      s_axis_tvalid_i <= 1'b0;
      load_taken = 1'b0;
    end
  end

  // result-side ready: long hold-off on request, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // monitor: check results, then record accepted inputs
  always @(posedge clk_i) begin
    mean_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_means.size() == 0) begin
        flag_mismatch("unexpected result, estimate_0", 0,
                      $signed(m_axis_tdata_o[SAMPLE_BITS-1:0]));
      end else begin
        want = expected_means.pop_front();
        for (int ch = 0; ch < NUM_LOADS; ch++)
          if (m_axis_tdata_o[ch*SAMPLE_BITS +: SAMPLE_BITS] !==
              want.means[ch*SAMPLE_BITS +: SAMPLE_BITS])
            flag_mismatch($sformatf("estimate_%0d", ch),
                          $signed(want.means[ch*SAMPLE_BITS +: SAMPLE_BITS]),
                          $signed(m_axis_tdata_o[ch*SAMPLE_BITS +: SAMPLE_BITS]));
        if (m_axis_tuser_o !== want.full)
          flag_mismatch("window_full", want.full, m_axis_tuser_o);
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_means.insert(expected_means.size(), average_update(s_axis_tdata_i));
      load_taken = 1'b1;
    end
  end

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_loads.size() != 0 || s_axis_tvalid_i || expected_means.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_window(logic [CFG_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    window_restart(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic load_vec_t pack_loads(logic [15:0] l0, logic [15:0] l1,
                                           logic [15:0] l2, logic [15:0] l3);
    return {l3, l2, l1, l0};
  endfunction

  // biased toward full-scale and near-zero values
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7, 0))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(8, 0) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic load_vec_t random_loads();
    return pack_loads(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endfunction

  initial begin
    logic [CFG_W-1:0] win;
    int unsigned w_eff;
    int unsigned n_items;
    int unsigned rand_sent;
    int unsigned phase;

    for (int s = 0; s < WINDOW_MAX; s++)
      for (int ch = 0; ch < NUM_LOADS; ch++) ring_q[s][ch] = '0;
    window_restart(WINDOW_RESET);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset window of 10: extremes, truncation of small negative sums, wrap
    add_load(pack_loads(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
    add_load(pack_loads(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001));
    add_load(pack_loads(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_load(pack_loads(16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF));
    for (int i = 0; i < 8; i++) add_load(random_loads());
    // window 0 behaves as 1
    write_window(7'd0);
    add_load(pack_loads(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    add_load(pack_loads(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    add_load(pack_loads(16'hFFFF, 16'h0001, 16'h0000, 16'h5555));
    // window above the maximum, changed again while still filling
    write_window(7'h7F);
    for (int i = 0; i < 3; i++) add_load(random_loads());
    write_window(7'd1);
    add_load(pack_loads(16'hAAAA, 16'h5555, 16'h8001, 16'h7FFE));
    add_load(pack_loads(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));

    // random phases: window settings swept, idle pattern rotating
    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RAND_ITEMS) begin
      case (phase)
        0: win = 7'd1;
        1: win = 7'd64;
        2: win = 7'd2;
        3: win = 7'h7F;
        4: win = 7'd0;
        5: win = 7'd65;
        6: win = 7'd33;
        7: win = 7'd3;
        default: win = ($urandom_range(9, 0) == 0) ? 7'($urandom_range(127, 0))
                                                   : 7'($urandom_range(64, 1));
      endcase
      write_window(win);
      w_eff = (win == 0) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : win;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 63; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 63; end
        default: begin send_idle_pct = 36; recv_idle_pct = 36; end
      endcase
      n_items = (w_eff >= 32) ? 160 : $urandom_range(100, 40);

      for (int i = 0; i < n_items / 2; i++) add_load(random_loads());
      // back-pressure: result side blocked while inputs keep coming
      if (phase == 0 || phase == 5) hold_req = 1'b1;
      // sender waits for every outstanding result before the second half
      wait_drained();
      for (int i = n_items / 2; i < n_items; i++) add_load(random_loads());

      rand_sent += n_items;
      phase++;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
